FILE: rtl/tfa_pkg.sv
// Types, widths and constants shared by the triangle face attributes core.
// No dependencies.
package tfa_pkg;

	localparam int VW    = 24;           // vertex coordinate, Q8.16
	localparam int EW    = VW + 1;       // edge vector component
	localparam int SUMW  = VW + 2;       // sum of three coordinates
	localparam int PW    = 2 * EW;       // edge product
	localparam int CW    = PW + 1;       // cross product component
	localparam int MW    = PW;           // cross magnitude
	localparam int HW    = MW / 2;       // half of a magnitude, for split squares
	localparam int SQW   = 2 * MW;       // square of a magnitude
	localparam int SW    = SQW + 2;      // sum of three squares
	localparam int LW    = (SW + 1) / 2; // integer square root
	localparam int NW    = 16;           // normal component, Q1.15
	localparam int AW    = 32;           // area, Q16.16
	localparam int AREA_SH = 17;         // length is in units of 2^-32, area halves it

	// divide by three: floor(x / 3) == (x * RECIP3) >> R3_SH for x < 2^R3_SH
	localparam int R3_SH = 29;
	localparam int R3W   = 28;
	localparam logic [R3W-1:0] RECIP3 = R3W'((64'd1 << R3_SH) / 3 + 1);
	localparam int PRW   = SUMW + R3W;
	localparam int QW    = PRW - R3_SH;

	localparam logic [NW-1:0] NORM_MAX = NW'((1 << (NW - 1)) - 1);

	typedef logic signed [VW-1:0] coord_t;

	typedef struct packed {
		coord_t vertex0_x;
		coord_t vertex0_y;
		coord_t vertex0_z;
		coord_t vertex1_x;
		coord_t vertex1_y;
		coord_t vertex1_z;
		coord_t vertex2_x;
		coord_t vertex2_y;
		coord_t vertex2_z;
	} vertex_set_t;

	typedef struct packed {
		coord_t center_x;
		coord_t center_y;
		coord_t center_z;
		logic signed [NW-1:0] normal_x;
		logic signed [NW-1:0] normal_y;
		logic signed [NW-1:0] normal_z;
		logic [AW-1:0] face_area;
		logic degenerate;
	} face_attr_t;

	// data riding along the square root pipe
	typedef struct packed {
		logic [2:0][VW-1:0] center;
		logic [2:0][MW-1:0] mag;
		logic [2:0] neg;
	} sq_side_t;

	// data riding along the normal divider
	typedef struct packed {
		logic [2:0][VW-1:0] center;
		logic [2:0] neg;
	} dv_side_t;

	function automatic logic signed [EW-1:0] sx_e(input coord_t v);
		sx_e = {v[VW-1], v};
	endfunction

	function automatic logic signed [SUMW-1:0] sx_s(input coord_t v);
		sx_s = {{(SUMW - VW){v[VW-1]}}, v};
	endfunction

endpackage

FILE: rtl/triangle_face_attributes_core.sv
// Triangle face attributes core: per-triangle area, centroid and unit normal.
// Depends on tfa_pkg, tfa_isqrt and tfa_ndiv.
//
// One triangle enters on every clock where start is high; busy is always low
// since the pipeline never stalls. The result item shows up on attrs with the
// done strobe for one cycle, and triangles leave in the order they came in.
// The receiver cannot stall, so it must take every item the cycle it appears.
// Each item passes through the square root (input register plus one root bit
// per stage, 52 stages) and the normal divider (input register plus one
// quotient bit per stage, 17 stages), behind seven stages of edge, cross
// product, magnitude and squaring work, plus the output register. min_area may
// be written over the cfg channel (always ready) whenever no triangle is in
// flight.
module triangle_face_attributes_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  tfa_pkg::vertex_set_t      vertices,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [tfa_pkg::AW-1:0]    cfg_data,
	output logic                      done,
	output tfa_pkg::face_attr_t       attrs
);
	import tfa_pkg::*;

	logic [AW-1:0] min_area_q;

	coord_t v0 [3];
	coord_t v1 [3];
	coord_t v2 [3];

	// stage 1: edges and coordinate sums
	logic signed [EW-1:0]   e1_s1 [3];
	logic signed [EW-1:0]   e2_s1 [3];
	logic signed [SUMW-1:0] sum_s1 [3];
	logic                   v_s1;
	// stage 2: edge products, centroid magnitude
	logic signed [PW-1:0]   pa_s2 [3];
	logic signed [PW-1:0]   pb_s2 [3];
	logic [SUMW-1:0]        cm_s2 [3];
	logic [2:0]             cneg_s2;
	logic                   v_s2;
	// stage 3: cross product, centroid reciprocal product
	logic signed [CW-1:0]   c_s3 [3];
	logic [PRW-1:0]         prod_s3 [3];
	logic [2:0]             cneg_s3;
	logic                   v_s3;
	// stage 4: magnitudes and finished centroid
	sq_side_t               sd_s4;
	logic                   v_s4;
	// stage 5: partial products of the squares
	logic [MW-1:0]          hh_s5 [3];
	logic [MW-1:0]          hl_s5 [3];
	logic [MW-1:0]          ll_s5 [3];
	sq_side_t               sd_s5;
	logic                   v_s5;
	// stage 6: squares
	logic [SQW-1:0]         sq_s6 [3];
	sq_side_t               sd_s6;
	logic                   v_s6;
	// stage 7: sum of squares
	logic [SW-1:0]          rad_s7;
	sq_side_t               sd_s7;
	logic                   v_s7;

	logic                   rt_valid;
	logic [LW-1:0]          rt_root;
	sq_side_t               rt_side;
	dv_side_t               dv_in_side;

	logic                   dv_valid;
	logic [2:0][NW-1:0]     dv_quot;
	logic [2:0]             dv_rnd;
	logic [LW-1:0]          dv_len;
	dv_side_t               dv_side;

	logic [2:0][NW-1:0]     norm;
	logic [AW-1:0]          area;
	logic                   degen;
	logic [QW-1:0]          cq [3];
	logic [2:0][VW-1:0]     cen;
	logic [2:0][MW-1:0]     cmag;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_area_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			min_area_q <= cfg_data;
		end
	end

	always_comb begin
		v0[0] = vertices.vertex0_x; v0[1] = vertices.vertex0_y; v0[2] = vertices.vertex0_z;
		v1[0] = vertices.vertex1_x; v1[1] = vertices.vertex1_y; v1[2] = vertices.vertex1_z;
		v2[0] = vertices.vertex2_x; v2[1] = vertices.vertex2_y; v2[2] = vertices.vertex2_z;
	end

	// valid bits follow the items down the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// centroid: round to nearest as floor((|s| + 1) / 3), sign put back after
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cq[k] = prod_s3[k][PRW-1:R3_SH];
			cen[k] = cneg_s3[k] ? VW'(QW'(0) - cq[k]) : VW'(cq[k]);
			cmag[k] = c_s3[k][CW-1] ? MW'(-c_s3[k]) : MW'(c_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			// stage 1
			e1_s1[k]  <= sx_e(v1[k]) - sx_e(v0[k]);
			e2_s1[k]  <= sx_e(v2[k]) - sx_e(v0[k]);
			sum_s1[k] <= sx_s(v0[k]) + sx_s(v1[k]) + sx_s(v2[k]);
			// stage 2
			cneg_s2[k] <= sum_s1[k][SUMW-1];
			cm_s2[k]   <= (sum_s1[k][SUMW-1] ? SUMW'(-sum_s1[k]) : SUMW'(sum_s1[k]))
				+ SUMW'(1);
			// stage 3
			c_s3[k]    <= CW'(pa_s2[k]) - CW'(pb_s2[k]);
			prod_s3[k] <= PRW'(cm_s2[k]) * PRW'(RECIP3);
			cneg_s3[k] <= cneg_s2[k];
			// stage 5: square of the 50-bit magnitude, split into 25-bit halves
			hh_s5[k] <= MW'(sd_s4.mag[k][MW-1:HW]) * MW'(sd_s4.mag[k][MW-1:HW]);
			hl_s5[k] <= MW'(sd_s4.mag[k][MW-1:HW]) * MW'(sd_s4.mag[k][HW-1:0]);
			ll_s5[k] <= MW'(sd_s4.mag[k][HW-1:0]) * MW'(sd_s4.mag[k][HW-1:0]);
			// stage 6
			sq_s6[k] <= (SQW'(hh_s5[k]) << (2 * HW)) + (SQW'(hl_s5[k]) << (HW + 1))
				+ SQW'(ll_s5[k]);
		end
		// stage 2: cross product terms
		pa_s2[0] <= e1_s1[1] * e2_s1[2];
		pb_s2[0] <= e1_s1[2] * e2_s1[1];
		pa_s2[1] <= e1_s1[2] * e2_s1[0];
		pb_s2[1] <= e1_s1[0] * e2_s1[2];
		pa_s2[2] <= e1_s1[0] * e2_s1[1];
		pb_s2[2] <= e1_s1[1] * e2_s1[0];
		// stage 4
		sd_s4.center <= cen;
		sd_s4.mag    <= cmag;
		sd_s4.neg    <= {c_s3[2][CW-1], c_s3[1][CW-1], c_s3[0][CW-1]};
		sd_s5 <= sd_s4;
		sd_s6 <= sd_s5;
		// stage 7
		rad_s7 <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
		sd_s7  <= sd_s6;
	end

	// cross product length: floor(sqrt(|c|^2))
	tfa_isqrt #(
		.SIDE_W ($bits(sq_side_t))
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s7),
		.radicand  (rad_s7),
		.in_side   (sd_s7),
		.out_valid (rt_valid),
		.root      (rt_root),
		.out_side  (rt_side)
	);

	assign dv_in_side.center = rt_side.center;
	assign dv_in_side.neg    = rt_side.neg;

	// normal components: |c| << 15 / len
	tfa_ndiv #(
		.SIDE_W ($bits(dv_side_t))
	) u_ndiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rt_valid),
		.len       (rt_root),
		.mag       (rt_side.mag),
		.in_side   (dv_in_side),
		.out_valid (dv_valid),
		.quot      (dv_quot),
		.rnd       (dv_rnd),
		.out_len   (dv_len),
		.out_side  (dv_side)
	);

	// final stage: round and saturate normal, area, degenerate test
	always_comb begin
		logic [NW:0] qr;
		qr = '0;
		for (int k = 0; k < 3; k++) begin
			qr = {1'b0, dv_quot[k]} + (NW + 1)'(dv_rnd[k]);
			if (dv_len == '0) begin
				qr = '0;
			end else if (qr > (NW + 1)'(NORM_MAX)) begin
				qr = (NW + 1)'(NORM_MAX);
			end
			norm[k] = dv_side.neg[k] ? NW'(-qr) : NW'(qr);
		end
		// area = len >> 17, saturated to 32 bits
		if (|dv_len[LW-1:AREA_SH+AW]) begin
			area = '1;
		end else begin
			area = dv_len[AREA_SH+AW-1:AREA_SH];
		end
		degen = (area <= min_area_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		attrs.center_x   <= dv_side.center[0];
		attrs.center_y   <= dv_side.center[1];
		attrs.center_z   <= dv_side.center[2];
		attrs.face_area  <= area;
		attrs.degenerate <= degen;
		if (degen) begin
			attrs.normal_x <= '0;
			attrs.normal_y <= '0;
			attrs.normal_z <= NORM_MAX;
		end else begin
			attrs.normal_x <= norm[0];
			attrs.normal_y <= norm[1];
			attrs.normal_z <= norm[2];
		end
	end

endmodule

FILE: rtl/tfa_isqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
// Depends on tfa_pkg.
module tfa_isqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [tfa_pkg::SW-1:0]  radicand,
	input  logic [SIDE_W-1:0]       in_side,
	output logic                    out_valid,
	output logic [tfa_pkg::LW-1:0]  root,
	output logic [SIDE_W-1:0]       out_side
);
	import tfa_pkg::*;

	localparam int N    = LW;
	localparam int RADW = 2 * LW;
	localparam int RW   = LW + 3;

	logic [RW-1:0]     rem_s  [0:N];
	logic [LW-1:0]     root_s [0:N];
	logic [RADW-1:0]   rad_s  [0:N];
	logic [SIDE_W-1:0] side_s [0:N];
	logic              vld_s  [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= '0;
		root_s[0] <= '0;
		rad_s[0]  <= RADW'(radicand);
		side_s[0] <= in_side;
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [RW-1:0] cur;
		logic [RW-1:0] trial;
		logic          ge;

		always_comb begin
			cur   = {rem_s[i][RW-3:0], rad_s[i][RADW-1 -: 2]};
			trial = RW'({root_s[i], 2'b01});
			ge    = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= ge ? (cur - trial) : cur;
			root_s[i+1] <= {root_s[i][LW-2:0], ge};
			rad_s[i+1]  <= {rad_s[i][RADW-3:0], 2'b00};
			side_s[i+1] <= side_s[i];
		end
	end

	assign out_valid = vld_s[N];
	assign root      = root_s[N];
	assign out_side  = side_s[N];

endmodule

FILE: rtl/tfa_ndiv.sv
// Pipelined restoring divider for the three normal components,
// quotient = (mag << 15) / len, one quotient bit per stage. Depends on tfa_pkg.
module tfa_ndiv #(
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [tfa_pkg::LW-1:0]       len,
	input  logic [2:0][tfa_pkg::MW-1:0]  mag,
	input  logic [SIDE_W-1:0]            in_side,
	output logic                         out_valid,
	output logic [2:0][tfa_pkg::NW-1:0]  quot,
	output logic [2:0]                   rnd,
	output logic [tfa_pkg::LW-1:0]       out_len,
	output logic [SIDE_W-1:0]            out_side
);
	import tfa_pkg::*;

	localparam int N  = NW;
	localparam int RW = LW + 2;

	logic [2:0][RW-1:0] rem_s  [0:N];
	logic [2:0][NW-1:0] q_s    [0:N];
	logic [LW-1:0]      len_s  [0:N];
	logic [SIDE_W-1:0]  side_s [0:N];
	logic               vld_s  [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			rem_s[0][c] <= RW'(mag[c]);
		end
		q_s[0]    <= '0;
		len_s[0]  <= len;
		side_s[0] <= in_side;
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [2:0][RW-1:0] cur;
		logic [2:0][RW-1:0] nrem;
		logic [2:0]         ge;

		always_comb begin
			for (int c = 0; c < 3; c++) begin
				// first step takes mag itself, since mag never exceeds len
				cur[c]  = (k == 0) ? rem_s[k][c] : {rem_s[k][c][RW-2:0], 1'b0};
				ge[c]   = (cur[c] >= RW'(len_s[k]));
				nrem[c] = ge[c] ? (cur[c] - RW'(len_s[k])) : cur[c];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			for (int c = 0; c < 3; c++) begin
				rem_s[k+1][c] <= nrem[c];
				q_s[k+1][c]   <= {q_s[k][c][NW-2:0], ge[c]};
			end
			len_s[k+1]  <= len_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			// round half up: remainder at least half the divisor
			rnd[c] = ({rem_s[N][c], 1'b0} >= (RW + 1)'(len_s[N]));
		end
	end

	assign out_valid = vld_s[N];
	assign quot      = q_s[N];
	assign out_len   = len_s[N];
	assign out_side  = side_s[N];

endmodule
